// ----- sv/fcr_pkg.sv -----
package fcr_pkg;

	// Frame signature and layout
	localparam logic [7:0] SIG_FIRST  = 8'hDE;
	localparam logic [7:0] SIG_SECOND = 8'hAF;

	localparam logic [3:0] FL_IDLE    = 4'd0;
	localparam logic [3:0] FL_SIG     = 4'd1;
	localparam logic [3:0] FL_CODE    = 4'd2;
	localparam logic [3:0] HEADER_LEN = 4'd3;
	localparam logic [3:0] SYNC_END   = 4'd7;
	localparam logic [3:0] XMIT_END   = 4'd11;

	// Command codes
	localparam logic [7:0] CODE_SYNC     = 8'd0;
	localparam logic [7:0] CODE_XMIT     = 8'd1;
	localparam logic [7:0] CODE_LOGRESET = 8'd2;
	localparam logic [7:0] CODE_CALIB    = 8'd3;

	// Item opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQSYNC = 2'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic        REQSYNC_RESET = 1'b1;

	localparam logic [15:0] IDLE_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_SYNC     = 3'd0,
		ST_XMIT     = 3'd1,
		ST_REFUSED  = 3'd2,
		ST_LOGRESET = 3'd3,
		ST_CALIB    = 3'd4,
		ST_BADCODE  = 3'd5,
		ST_TIMEOUT  = 3'd6
	} status_t;

	// Event handed from the parser to the executor
	typedef struct packed {
		status_t     status;
		logic [63:0] payload;
	} event_t;

endpackage

// ----- sv/fcr_cmd_if.sv -----
interface fcr_cmd_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source(output valid, output op, output rx_byte, input ready);
	modport sink(input valid, input op, input rx_byte, output ready);
endinterface

// ----- sv/fcr_rsp_if.sv -----
interface fcr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] payload;

	modport source(output valid, output status, output payload, input ready);
	modport sink(input valid, input status, input payload, output ready);
endinterface

// ----- sv/fcr_cfg_if.sv -----
interface fcr_cfg_if import fcr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/framed_command_receiver.sv -----
// Channel  Role    Payload                         Handshake
// cmd      sink    op[0], rx_byte[7:0]             valid/ready
// rsp      source  status[2:0], payload[63:0]      valid/ready
// cfg      sink    index[1:0], data[15:0]          valid/ready, ready tied high
//
// One item per cycle sustained while the event queue has room; a result passes
// through the event queue and the output register before it is presented on
// rsp, and is held there while rsp is stalled.
// cmd.ready drops only when the event queue (QDEPTH entries) is full.
// Reset clears frame state, the synced flag and the queue and loads
// timeout_ticks = 2000, require_sync = 1.
// A stall on rsp backs up through the output register and the queue.
module framed_command_receiver import fcr_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	fcr_cmd_if.sink    cmd,
	fcr_rsp_if.source  rsp,
	fcr_cfg_if.sink    cfg
);

	logic [15:0] timeout_ticks_q;
	logic        require_sync_q;

	logic   accept;
	logic   ev_push;
	event_t ev_new;
	logic   q_not_full;
	logic   q_not_empty;
	logic   q_pop;
	event_t q_head;

	// Configuration: always ready, drop writes to unknown indexes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
			require_sync_q  <= REQSYNC_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_TIMEOUT)
				timeout_ticks_q <= cfg.data;
			else if (cfg.index == REG_REQSYNC)
				require_sync_q <= cfg.data[0];
		end
	end

	// Front: take an item whenever the queue can hold the event it may raise
	assign cmd.ready = q_not_full;
	assign accept    = cmd.valid && q_not_full;

	fcr_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.op            (cmd.op),
		.rx_byte       (cmd.rx_byte),
		.timeout_ticks (timeout_ticks_q),
		.push          (ev_push),
		.ev            (ev_new)
	);

	// Decouple the parser from the output side
	fcr_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_ev   (ev_new),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: resolve sync gating and hold the result until taken
	fcr_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.require_sync (require_sync_q),
		.ev_valid     (q_not_empty),
		.ev           (q_head),
		.pop          (q_pop),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_status   (rsp.status),
		.out_payload  (rsp.payload)
	);

endmodule

// ----- sv/fcr_parser.sv -----
module fcr_parser import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] timeout_ticks,
	output logic        push,
	output event_t      ev
);

	logic [3:0]  fl_q, fl_d;
	logic        xmit_q, xmit_d;
	logic [15:0] idle_q, idle_d;
	logic [63:0] pay_q, pay_d;
	logic [3:0]  fl_inc;
	logic [3:0]  fl_off;
	logic [2:0]  idx;

	assign fl_inc = fl_q + 4'd1;
	assign fl_off = fl_q - HEADER_LEN;
	assign idx    = fl_off[2:0];

	always_comb begin
		fl_d       = fl_q;
		xmit_d     = xmit_q;
		idle_d     = idle_q;
		pay_d      = pay_q;
		push       = 1'b0;
		ev.status  = ST_SYNC;
		ev.payload = '0;
		if (accept) begin
			if (op == OP_TICK) begin
				if (idle_q != IDLE_MAX)
					idle_d = idle_q + 16'd1;
				if (fl_q > FL_SIG && idle_d > timeout_ticks) begin
					push      = 1'b1;
					ev.status = ST_TIMEOUT;
					fl_d      = FL_IDLE;
				end
			end else begin
				idle_d = '0;
				unique case (fl_q)
					FL_IDLE: begin
						if (rx_byte == SIG_FIRST)
							fl_d = FL_SIG;
					end
					FL_SIG: begin
						fl_d = (rx_byte == SIG_SECOND) ? FL_CODE : FL_IDLE;
					end
					FL_CODE: begin
						priority if (rx_byte == CODE_LOGRESET) begin
							push      = 1'b1;
							ev.status = ST_LOGRESET;
							fl_d      = FL_IDLE;
						end else if (rx_byte == CODE_CALIB) begin
							push      = 1'b1;
							ev.status = ST_CALIB;
							fl_d      = FL_IDLE;
						end else if (rx_byte > CODE_CALIB) begin
							push      = 1'b1;
							ev.status = ST_BADCODE;
							fl_d      = FL_IDLE;
						end else begin
							xmit_d = (rx_byte == CODE_XMIT);
							pay_d  = '0;
							fl_d   = HEADER_LEN;
						end
					end
					default: begin
						pay_d[{idx, 3'b000} +: 8] = rx_byte;
						fl_d = fl_inc;
						if (!xmit_q && fl_inc >= SYNC_END) begin
							push       = 1'b1;
							ev.status  = ST_SYNC;
							ev.payload = {32'd0, pay_d[31:0]};
							fl_d       = FL_IDLE;
						end else if (xmit_q && fl_inc >= XMIT_END) begin
							push       = 1'b1;
							ev.status  = ST_XMIT;
							ev.payload = pay_d;
							fl_d       = FL_IDLE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q   <= FL_IDLE;
			xmit_q <= 1'b0;
			idle_q <= '0;
		end else begin
			fl_q   <= fl_d;
			xmit_q <= xmit_d;
			idle_q <= idle_d;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= pay_d;
	end

	// A frame never grows past the last transmit payload byte
	a_fl_range: assert property (@(posedge clk) disable iff (!arst_n)
		fl_q < XMIT_END)
		else $error("frame length out of range");

	// Every completed frame returns the parser to signature hunting
	a_push_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> fl_q == FL_IDLE)
		else $error("parser did not restart after an event");

endmodule

// ----- sv/fcr_queue.sv -----
module fcr_queue import fcr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_ev,
	output logic   not_full,
	input  logic   pop,
	output logic   not_empty,
	output event_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL  = CNT_W'(DEPTH);

	event_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign not_full  = cnt_q != FULL;
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// An event offered to a full queue would be lost
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("event pushed into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("queue count out of range");

endmodule

// ----- sv/fcr_exec.sv -----
module fcr_exec import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        require_sync,
	input  logic        ev_valid,
	input  event_t      ev,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic [63:0] out_payload
);

	logic        synced_q;
	logic        valid_q;
	status_t     status_q;
	logic [63:0] payload_q;
	logic        refuse;

	assign pop    = ev_valid && (!valid_q || out_ready);
	assign refuse = (ev.status == ST_XMIT) && require_sync && !synced_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (pop && ev.status == ST_SYNC)
				synced_q <= 1'b1;
			if (pop)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= refuse ? ST_REFUSED : ev.status;
			payload_q <= refuse ? '0 : ev.payload;
		end
	end

	assign out_valid   = valid_q;
	assign out_status  = status_q;
	assign out_payload = payload_q;

	// A refused request never leaks its payload
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == ST_REFUSED |-> payload_q == '0)
		else $error("refused transmit carries payload");

	// Once synced, a transmit request is never refused
	a_no_refuse_synced: assert property (@(posedge clk) disable iff (!arst_n)
		pop && synced_q && ev.status == ST_XMIT |=> status_q == ST_XMIT)
		else $error("transmit refused after sync");

endmodule

// ----- tb/framed_command_receiver_tb.sv -----
module framed_command_receiver_tb;
	import fcr_pkg::*;

	// Codes and indexes beyond the ones the package names
	localparam logic [7:0] CODE_FIRST_UNKNOWN = 8'd4;
	localparam logic [7:0] CODE_TOP           = 8'hFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES  = 10;
	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int unsigned RANDOM_PHASE_ITEMS = 200;

	logic clk;
	logic arst_n;

	fcr_cmd_if cmd_ch ();
	fcr_rsp_if rsp_ch ();
	fcr_cfg_if cfg_ch ();

	framed_command_receiver uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Frame parser mirror: current frame, idle ticks, synced flag
	logic [3:0]  frame_len;
	logic [7:0]  frame_code;
	logic [63:0] assembled;
	logic [15:0] idle_ticks;
	logic        synced_flag;
	// Register mirror
	logic [15:0] timeout_limit;
	logic        sync_required;

	event_t      pending_events[$];
	int unsigned mismatch_count;
	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned rsp_hold_request;
	int unsigned cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the parser mirror by one item; return 1 when the item completes a result.
	function automatic bit next_frame_event(input logic op, input logic [7:0] b,
			output event_t res);
		int unsigned idx;
		res = '0;
		if (op == OP_TICK) begin
			if (idle_ticks != IDLE_MAX)
				idle_ticks = idle_ticks + 16'd1;
			// Only a frame past its first signature byte can expire
			if (frame_len > FL_SIG && idle_ticks > timeout_limit) begin
				res.status = ST_TIMEOUT;
				frame_len = FL_IDLE;
				return 1'b1;
			end
			return 1'b0;
		end
		idle_ticks = '0;
		if (frame_len == FL_IDLE) begin
			if (b == SIG_FIRST)
				frame_len = FL_SIG;
			return 1'b0;
		end
		// A wrong second byte drops the frame and is not taken as a new first byte
		if (frame_len == FL_SIG) begin
			frame_len = (b == SIG_SECOND) ? FL_CODE : FL_IDLE;
			return 1'b0;
		end
		if (frame_len == FL_CODE) begin
			frame_code = b;
			assembled = '0;
			frame_len = HEADER_LEN;
			if (b == CODE_LOGRESET)
				res.status = ST_LOGRESET;
			else if (b == CODE_CALIB)
				res.status = ST_CALIB;
			else if (b > CODE_CALIB)
				res.status = ST_BADCODE;
			else
				return 1'b0;
			frame_len = FL_IDLE;
			return 1'b1;
		end
		// Payload byte, little-endian
		idx = int'(frame_len - HEADER_LEN) & 7;
		assembled = assembled | (64'(b) << (8 * idx));
		frame_len = frame_len + 4'd1;
		if (frame_code == CODE_SYNC) begin
			if (frame_len < SYNC_END)
				return 1'b0;
			synced_flag = 1'b1;
			res.status = ST_SYNC;
			res.payload = {32'd0, assembled[31:0]};
		end else if (frame_code == CODE_XMIT) begin
			if (frame_len < XMIT_END)
				return 1'b0;
			if (synced_flag || !sync_required) begin
				res.status = ST_XMIT;
				res.payload = assembled;
			end else begin
				res.status = ST_REFUSED;
			end
		end else begin
			res.status = ST_BADCODE;
		end
		frame_len = FL_IDLE;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Predict on every accepted item, check every accepted result against the oldest prediction.
	// Push before pop: a result never leaves in the cycle of its own item.
	always @(posedge clk) begin : check_results
		event_t predicted;
		event_t oldest;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (next_frame_event(cmd_ch.op, cmd_ch.rx_byte, predicted))
					pending_events.push_back(predicted);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_events.size() == 0) begin
					note_mismatch($sformatf("unexpected result status %0d payload %h",
						rsp_ch.status, rsp_ch.payload));
				end else begin
					oldest = pending_events.pop_front();
					if (rsp_ch.status !== oldest.status)
						note_mismatch($sformatf("status expected %0d actual %0d",
							oldest.status, rsp_ch.status));
					if (rsp_ch.payload !== oldest.payload)
						note_mismatch($sformatf("payload expected %h actual %h",
							oldest.payload, rsp_ch.payload));
				end
			end
		end
	end

	// Result receiver: random stall rate that changes in stretches, plus an
	// occasional long hold-off counted here in cycles.
	initial begin : drive_rsp_ready
		int unsigned stall_pct;
		int unsigned mode_left;
		int unsigned hold_left;
		rsp_ch.ready = 1'b0;
		stall_pct = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_hold_request != 0) begin
				hold_left = rsp_hold_request;
				rsp_hold_request = 0;
			end
			if (mode_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1:    stall_pct = 0;
					2:       stall_pct = 30;
					3:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(1, 100) > stall_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("framed_command_receiver_tb NOT OK");
			$finish;
		end
	end

	// Offer one item and hold it until accepted; insert a random gap between bursts.
	task automatic send_item(input logic op, input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120)
				: $urandom_range(1, 24);
		end
		burst_left--;
		cmd_ch.valid   <= 1'b1;
		cmd_ch.op      <= op;
		cmd_ch.rx_byte <= b;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
	endtask

	// Ticks carry a random byte that the block must ignore
	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(OP_TICK, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b);
	endtask

	// Signature, code, then nbytes of data little-endian, each byte preceded by up to max_ticks ticks
	task automatic send_frame(input logic [7:0] code, input logic [63:0] data,
			input int unsigned nbytes, input int unsigned max_ticks);
		send_byte(SIG_FIRST);
		send_byte(SIG_SECOND);
		send_byte(code);
		for (int i = 0; i < nbytes; i++) begin
			if (max_ticks != 0)
				send_ticks($urandom_range(0, max_ticks));
			send_byte(data[8*i +: 8]);
		end
	endtask

	// Stop offering, wait out every prediction, then let in-flight no-result items settle
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT: timeout_limit = value;
			REG_REQSYNC: sync_required = value[0];
			default: ;
		endcase
	endtask

	// Transmit request before any sync, with the reset setting: refused
	task automatic test_refused_before_sync();
		send_frame(CODE_XMIT, 64'h0123_4567_89AB_CDEF, 8, 0);
		wait_drained();
	endtask

	// Drop the sync requirement: the same request goes through unsynced
	task automatic test_sync_not_required();
		write_register(REG_REQSYNC, {15'($urandom), 1'b0});
		send_frame(CODE_XMIT, 64'hFEDC_BA98_7654_3210, 8, 0);
		wait_drained();
		write_register(REG_REQSYNC, {15'($urandom), 1'b1});
	endtask

	// Every command with extreme payloads, a repeated sync, both ends of the unknown codes
	task automatic test_every_command();
		send_frame(CODE_SYNC, 64'hFFFF_FFFF, 4, 0);
		send_frame(CODE_XMIT, '1, 8, 0);
		send_frame(CODE_XMIT, '0, 8, 0);
		send_frame(CODE_SYNC, '0, 4, 0);
		send_frame(CODE_LOGRESET, '0, 0, 0);
		send_frame(CODE_CALIB, '0, 0, 0);
		send_frame(CODE_FIRST_UNKNOWN, '0, 0, 0);
		send_frame(CODE_TOP, '0, 0, 0);
		wait_drained();
	endtask

	// Bad signature bytes: drop silently, then hunt for the first signature byte again
	task automatic test_signature_recovery();
		send_byte(SIG_FIRST);
		send_byte(SIG_FIRST);
		send_byte(SIG_SECOND);
		send_byte(CODE_LOGRESET);
		send_byte(SIG_FIRST);
		send_byte(8'h00);
		send_byte(SIG_SECOND);
		send_frame(CODE_CALIB, '0, 0, 0);
		wait_drained();
	endtask

	task automatic test_timeout_edges();
		write_register(REG_TIMEOUT, 16'd0);
		write_register(REG_UNUSED, 16'($urandom));
		// A lone first signature byte never expires, even at timeout 0
		send_byte(SIG_FIRST);
		send_ticks(3);
		send_byte(SIG_SECOND);
		send_byte(CODE_LOGRESET);
		// Two bytes in and a single tick is enough at timeout 0
		send_byte(SIG_FIRST);
		send_byte(SIG_SECOND);
		send_ticks(1);
		wait_drained();
		// Ticks equal to the limit are still fine, one more expires
		write_register(REG_TIMEOUT, 16'd3);
		send_frame(CODE_SYNC, 64'($urandom), 4, 3);
		send_frame(CODE_XMIT, '0, 1, 0);
		send_ticks(4);
		wait_drained();
		write_register(REG_TIMEOUT, TIMEOUT_RESET);
	endtask

	// The largest limit keeps a partial frame alive; lowering it expires the frame on the next tick
	task automatic test_large_limit();
		write_register(REG_TIMEOUT, IDLE_MAX);
		send_byte(SIG_FIRST);
		send_byte(SIG_SECOND);
		send_byte(CODE_SYNC);
		send_ticks(40);
		wait_drained();
		write_register(REG_TIMEOUT, 16'd20);
		send_ticks(1);
		wait_drained();
		write_register(REG_TIMEOUT, TIMEOUT_RESET);
	endtask

	// Hold the receiver off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		rsp_hold_request = 400;
		repeat (40)
			send_frame(CODE_LOGRESET, '0, 0, 0);
		wait_drained();
	endtask

	task automatic random_frame();
		int unsigned pick;
		int unsigned max_ticks;
		logic [7:0]  code;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			code = CODE_SYNC;
		else if (pick < 70)
			code = CODE_XMIT;
		else if (pick < 80)
			code = CODE_LOGRESET;
		else if (pick < 90)
			code = CODE_CALIB;
		else
			code = 8'($urandom_range(int'(CODE_FIRST_UNKNOWN), int'(CODE_TOP)));
		// Mostly short pauses between bytes, sometimes long enough to expire
		if ($urandom_range(0, 3) == 0)
			max_ticks = (int'(timeout_limit) + 2 < 60) ? int'(timeout_limit) + 2 : 60;
		else
			max_ticks = $urandom_range(0, 2);
		send_frame(code, {$urandom, $urandom},
			(code == CODE_SYNC) ? 4 : (code == CODE_XMIT) ? 8 : 0, max_ticks);
	endtask

	// Header of a sync or transmit with too few data bytes, then an idle stretch
	task automatic truncated_frame();
		logic [7:0]  code;
		int unsigned run;
		code = $urandom_range(0, 1) ? CODE_XMIT : CODE_SYNC;
		send_frame(code, {$urandom, $urandom},
			$urandom_range(0, (code == CODE_SYNC) ? 3 : 7), 0);
		run = int'(timeout_limit) + 1 + $urandom_range(0, 3);
		send_ticks((run < 80) ? run : 80);
	endtask

	task automatic broken_signature();
		logic [7:0] b;
		b = 8'($urandom);
		if ($urandom_range(0, 1)) begin
			send_byte(SIG_FIRST);
			send_byte((b == SIG_SECOND) ? ~b : b);
		end else begin
			send_byte((b == SIG_FIRST) ? ~b : b);
		end
	endtask

	// Well-formed frames with random content make up most of it; the rest is noise
	task automatic test_random_traffic();
		logic [15:0] limits[7];
		int unsigned start;
		int unsigned pick;
		limits = '{16'd0, 16'd1, 16'd3, 16'd10, 16'd40, IDLE_MAX,
			16'($urandom_range(2, 30))};
		foreach (limits[p]) begin
			wait_drained();
			write_register(REG_TIMEOUT, limits[p]);
			write_register(REG_REQSYNC, {15'($urandom), 1'($urandom)});
			start = items_sent;
			while (items_sent - start < RANDOM_PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					random_frame();
				else if (pick < 72)
					truncated_frame();
				else if (pick < 82)
					broken_signature();
				else if (pick < 92)
					send_ticks($urandom_range(1, 40));
				else
					repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_BYTE;
		cmd_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TIMEOUT;
		cfg_ch.data = '0;
		frame_len = FL_IDLE;
		frame_code = '0;
		assembled = '0;
		idle_ticks = '0;
		synced_flag = 1'b0;
		timeout_limit = TIMEOUT_RESET;
		sync_required = REQSYNC_RESET;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		rsp_hold_request = 0;
		cycle_count = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refused_before_sync();
		test_sync_not_required();
		test_every_command();
		test_signature_recovery();
		test_timeout_edges();
		test_large_limit();
		test_backpressure();
		test_random_traffic();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_events.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_events.size()));
		if (mismatch_count == 0)
			$display("framed_command_receiver_tb OK");
		else
			$display("framed_command_receiver_tb NOT OK");
		$finish;
	end

endmodule
